>>> rtl/core/msc_pkg.sv
// shared types and constants of the merge sort block
package msc_pkg;

    localparam int DATA_W = 32;
    localparam int CNT_W  = 9;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_INIT,
        ST_SPLIT,
        ST_RET,
        ST_COPY,
        ST_COPY_END,
        ST_MRD,
        ST_MWR,
        ST_EMIT_RD,
        ST_EMIT_LD
    } msc_state_t;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_INIT,
        OP_PUSH,
        OP_RIGHT,
        OP_POP,
        OP_COPY,
        OP_MSETUP,
        OP_MRD,
        OP_MWR,
        OP_EMIT_RD,
        OP_EMIT_LD
    } msc_op_t;

    typedef struct packed {
        logic seg_split;
        logic stack_empty;
        logic top_merge;
        logic seg_last;
        logic emit_last;
        logic out_busy;
    } msc_sts_t;

endpackage

>>> rtl/core/msc_ctrl.sv
// sequencer state machine of the merge sort block
module msc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_last,
    output logic              s_ready,
    input  msc_pkg::msc_sts_t sts,
    output msc_pkg::msc_op_t  cmd
);
    import msc_pkg::*;

    msc_state_t state_reg;
    msc_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = OP_IDLE;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd = OP_LOAD;
                    if (s_last) begin
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT: begin
                cmd        = OP_INIT;
                state_next = ST_SPLIT;
            end
            ST_SPLIT: begin
                if (sts.seg_split) begin
                    cmd = OP_PUSH;
                end else begin
                    state_next = ST_RET;
                end
            end
            ST_RET: begin
                if (sts.stack_empty) begin
                    state_next = ST_EMIT_RD;
                end else if (sts.top_merge) begin
                    cmd        = OP_POP;
                    state_next = ST_COPY;
                end else begin
                    cmd        = OP_RIGHT;
                    state_next = ST_SPLIT;
                end
            end
            ST_COPY: begin
                cmd = OP_COPY;
                if (sts.seg_last) begin
                    state_next = ST_COPY_END;
                end
            end
            ST_COPY_END: begin
                cmd        = OP_MSETUP;
                state_next = ST_MRD;
            end
            ST_MRD: begin
                cmd        = OP_MRD;
                state_next = ST_MWR;
            end
            ST_MWR: begin
                cmd        = OP_MWR;
                state_next = sts.seg_last ? ST_RET : ST_MRD;
            end
            ST_EMIT_RD: begin
                if (!sts.out_busy) begin
                    cmd        = OP_EMIT_RD;
                    state_next = ST_EMIT_LD;
                end
            end
            ST_EMIT_LD: begin
                cmd        = OP_EMIT_LD;
                state_next = sts.emit_last ? ST_LOAD : ST_EMIT_RD;
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

>>> rtl/core/msc_dp.sv
// datapath of the merge sort block: stores, segment stack, merge pointers, output register
module msc_dp #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  msc_pkg::msc_op_t                    cmd,
    output msc_pkg::msc_sts_t                   sts,
    input  logic signed [msc_pkg::DATA_W-1:0]   s_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [msc_pkg::DATA_W-1:0]   m_value_res,
    output logic        [msc_pkg::CNT_W-1:0]    m_comparison_count,
    output logic                                m_dropped,
    output logic                                m_last_res
);
    import msc_pkg::*;

    localparam int AW  = $clog2(MAX_ELEMENTS);
    localparam int CW  = $clog2(MAX_ELEMENTS + 1);
    localparam int LOG = AW;
    localparam int SW  = $clog2(LOG + 1);
    localparam int LW  = (LOG > 1) ? $clog2(LOG) : 1;

    function automatic logic [AW-1:0] mid_of(input logic [AW-1:0] lo, input logic [AW-1:0] hi);
        logic [AW-1:0] d;
        d = hi - lo;
        return lo + (d >> 1);
    endfunction

    logic [DATA_W-1:0] elem_mem [MAX_ELEMENTS];
    logic [DATA_W-1:0] scr_mem  [MAX_ELEMENTS];
    logic [DATA_W-1:0] e_rdata_reg;
    logic [DATA_W-1:0] sa_reg;
    logic [DATA_W-1:0] sb_reg;

    logic [CW-1:0]     count_reg;
    logic              ovf_reg;
    logic [CNT_W-1:0]  total_reg;
    logic [SW-1:0]     sp_reg;
    logic              m_valid_reg;
    logic              cp_v_reg;
    logic [AW-1:0]     cp_addr_reg;

    logic [AW-1:0]     stk_lo_reg [LOG];
    logic [AW-1:0]     stk_hi_reg [LOG];
    logic              stk_ph_reg [LOG];
    logic [AW-1:0]     cur_lo_reg;
    logic [AW-1:0]     cur_hi_reg;
    logic [AW-1:0]     lo_m_reg;
    logic [AW-1:0]     mid_m_reg;
    logic [AW-1:0]     hi_m_reg;
    logic [CW-1:0]     a_reg;
    logic [CW-1:0]     b_reg;
    logic [AW-1:0]     k_reg;
    logic [AW-1:0]     emit_idx_reg;

    logic signed [DATA_W-1:0] out_value_reg;
    logic [CNT_W-1:0]  out_count_reg;
    logic              out_drop_reg;
    logic              out_last_reg;

    logic [SW-1:0]     sp_m1;
    logic [LW-1:0]     top_idx;
    logic [LW-1:0]     push_idx;
    logic [AW-1:0]     top_mid;
    logic [CW-1:0]     count_m1;
    logic              store_full;
    logic              emit_last;
    logic              a_ok;
    logic              b_ok;
    logic              take_a;
    logic [AW-1:0]     e_raddr;

    assign sp_m1      = sp_reg - 1'b1;
    assign top_idx    = sp_m1[LW-1:0];
    assign push_idx   = sp_reg[LW-1:0];
    assign top_mid    = mid_of(stk_lo_reg[top_idx], stk_hi_reg[top_idx]);
    assign count_m1   = count_reg - 1'b1;
    assign store_full = (count_reg >= CW'(MAX_ELEMENTS));
    assign emit_last  = (CW'(emit_idx_reg) == count_m1);
    assign a_ok       = (a_reg <= CW'(mid_m_reg));
    assign b_ok       = (b_reg <= CW'(hi_m_reg));
    assign take_a     = a_ok && (!b_ok || ($signed(sa_reg) <= $signed(sb_reg)));
    assign e_raddr    = (cmd == OP_EMIT_RD) ? emit_idx_reg : k_reg;

    assign sts.seg_split   = (cur_lo_reg < cur_hi_reg);
    assign sts.stack_empty = (sp_reg == '0);
    assign sts.top_merge   = stk_ph_reg[top_idx];
    assign sts.seg_last    = (k_reg == hi_m_reg);
    assign sts.emit_last   = emit_last;
    assign sts.out_busy    = m_valid_reg;

    // element store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd == OP_LOAD && !store_full) begin
            elem_mem[count_reg[AW-1:0]] <= s_value;
        end else if (cmd == OP_MWR) begin
            elem_mem[k_reg] <= take_a ? sa_reg : sb_reg;
        end
        e_rdata_reg <= elem_mem[e_raddr];
    end

    // scratch store: written by the copy pass, read at both merge heads
    always_ff @(posedge aclk) begin
        if (cp_v_reg) begin
            scr_mem[cp_addr_reg] <= e_rdata_reg;
        end
        sa_reg <= scr_mem[a_reg[AW-1:0]];
        sb_reg <= scr_mem[b_reg[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            sp_reg      <= '0;
            m_valid_reg <= 1'b0;
            cp_v_reg    <= 1'b0;
        end else begin
            cp_v_reg <= (cmd == OP_COPY);
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (cmd)
                OP_LOAD: begin
                    if (!store_full) begin
                        count_reg <= count_reg + 1'b1;
                    end else begin
                        ovf_reg <= 1'b1;
                    end
                end
                OP_INIT: sp_reg <= '0;
                OP_PUSH: sp_reg <= sp_reg + 1'b1;
                OP_POP:  sp_reg <= sp_reg - 1'b1;
                OP_EMIT_LD: begin
                    m_valid_reg <= 1'b1;
                    if (emit_last) begin
                        count_reg <= '0;
                        ovf_reg   <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        cp_addr_reg <= k_reg;
        unique case (cmd)
            OP_INIT: begin
                total_reg    <= '0;
                cur_lo_reg   <= '0;
                cur_hi_reg   <= count_m1[AW-1:0];
                emit_idx_reg <= '0;
            end
            OP_PUSH: begin
                stk_lo_reg[push_idx] <= cur_lo_reg;
                stk_hi_reg[push_idx] <= cur_hi_reg;
                stk_ph_reg[push_idx] <= 1'b0;
                cur_hi_reg           <= mid_of(cur_lo_reg, cur_hi_reg);
            end
            OP_RIGHT: begin
                stk_ph_reg[top_idx] <= 1'b1;
                cur_lo_reg          <= top_mid + 1'b1;
                cur_hi_reg          <= stk_hi_reg[top_idx];
            end
            OP_POP: begin
                lo_m_reg  <= stk_lo_reg[top_idx];
                mid_m_reg <= top_mid;
                hi_m_reg  <= stk_hi_reg[top_idx];
                k_reg     <= stk_lo_reg[top_idx];
            end
            OP_COPY: k_reg <= k_reg + 1'b1;
            OP_MSETUP: begin
                a_reg <= CW'(lo_m_reg);
                b_reg <= CW'(mid_m_reg) + 1'b1;
                k_reg <= lo_m_reg;
            end
            OP_MWR: begin
                k_reg     <= k_reg + 1'b1;
                total_reg <= total_reg + 1'b1;
                if (take_a) begin
                    a_reg <= a_reg + 1'b1;
                end else begin
                    b_reg <= b_reg + 1'b1;
                end
            end
            OP_EMIT_LD: begin
                out_value_reg <= e_rdata_reg;
                out_count_reg <= total_reg;
                out_drop_reg  <= ovf_reg;
                out_last_reg  <= emit_last;
                emit_idx_reg  <= emit_idx_reg + 1'b1;
            end
            default: ;
        endcase
    end

    assign m_valid            = m_valid_reg;
    assign m_value_res        = out_value_reg;
    assign m_comparison_count = out_count_reg;
    assign m_dropped          = out_drop_reg;
    assign m_last_res         = out_last_reg;

endmodule

>>> rtl/core/merge_sort_with_count.sv
// top level of the merge sort block with placement count
// Loads signed Q16.16 values one transfer per cycle until the transfer marked last
// (up to MAX_ELEMENTS are kept, further items are dropped and flagged), then sorts
// them ascending and stable by top-down merge sort with a six-entry segment stack
// (depth log2 MAX_ELEMENTS) and emits them in order. Every merge first copies its
// segment to the scratch store and then places its elements one at a time, each
// write after a scratch read state, since the scratch store's registered read sits
// in the compare loop. With n loaded items, n a power of two, the sort makes
// n*log2 n placements.
// The last result waits in the output register while the next set is already loading.
module merge_sort_with_count #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [msc_pkg::DATA_W-1:0]   s_value,
    input  logic                                s_last,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [msc_pkg::DATA_W-1:0]   m_value_res,
    output logic        [msc_pkg::CNT_W-1:0]    m_comparison_count,
    output logic                                m_dropped,
    output logic                                m_last_res
);
    import msc_pkg::*;

    // command from the sequencer, status back from the datapath
    msc_op_t  dp_cmd;
    msc_sts_t dp_sts;

    // sequencer: load, split and merge walk over the segment stack, emit
    msc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_last),
        .s_ready (s_ready),
        .sts     (dp_sts),
        .cmd     (dp_cmd)
    );

    // datapath: element and scratch stores, stack, pointers, output register
    msc_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (dp_cmd),
        .sts                (dp_sts),
        .s_value            (s_value),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_value_res        (m_value_res),
        .m_comparison_count (m_comparison_count),
        .m_dropped          (m_dropped),
        .m_last_res         (m_last_res)
    );

    // output register is only loaded when empty
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (dp_cmd == OP_EMIT_LD) |-> !m_valid)
        else $error("result register overwritten");

    // no input transfer while a set is still being emitted
    a_no_load_mid_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last_res) |-> !s_ready)
        else $error("input taken during emission");

    // every placement follows a scratch read cycle
    a_merge_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (dp_cmd == OP_MWR) |-> ($past(dp_cmd) == OP_MRD))
        else $error("placement without scratch read");

    // a pop or a right-half step only happens with a non-empty stack
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (dp_cmd == OP_POP || dp_cmd == OP_RIGHT) |-> !dp_sts.stack_empty)
        else $error("stack underflow");

endmodule

>>> tb/tb_merge_sort_with_count.sv
`timescale 1ns / 100ps
// self-checking testbench for the merge sort block with placement count
module tb_merge_sort_with_count;
    import msc_pkg::*;

    localparam int MAX_ELEMENTS      = 64;
    // the watchdog sits well above both the quiet stretch of a full-store sort
    // and the long output hold
    localparam int WATCHDOG_LIMIT    = 20000;
    localparam int RX_HOLD_CYCLES    = 3000;
    localparam int END_SETTLE_CYCLES = 200;

    typedef logic signed [DATA_W-1:0] q16_t;

    // one sorted element as it should leave the block
    typedef struct packed {
        q16_t             value_res;
        logic [CNT_W-1:0] comparison_count;
        logic             dropped;
        logic             last_res;
    } sorted_result_t;

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    q16_t             s_value;
    logic             s_last;
    logic             m_valid;
    logic             m_ready;
    q16_t             m_value_res;
    logic [CNT_W-1:0] m_comparison_count;
    logic             m_dropped;
    logic             m_last_res;

    // predictor state: the set being loaded and the results still owed
    q16_t           loaded_values[$];
    logic           set_overflow = 1'b0;
    sorted_result_t sorted_queue[$];

    // idling controls, percent of cycles
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;

    // long output hold, requested by a test and counted by the result sink
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;

    int error_count     = 0;
    int items_sent      = 0;
    int sets_closed     = 0;
    int dropped_sets    = 0;
    int results_checked = 0;

    always #5 aclk = ~aclk;

    merge_sort_with_count #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_value            (s_value),
        .s_last             (s_last),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_value_res        (m_value_res),
        .m_comparison_count (m_comparison_count),
        .m_dropped          (m_dropped),
        .m_last_res         (m_last_res)
    );

    // placements made by top-down merge sort over n elements: every merge
    // places each element of its segment once; the left half takes the
    // midpoint, so it holds ceil(n/2)
    function automatic int unsigned merge_placements(input int unsigned n);
        if (n < 2)
            return 0;
        return n + merge_placements((n + 1) / 2) + merge_placements(n / 2);
    endfunction

    // track one accepted input; on the closing item sort the set and queue
    // the expected results
    task automatic load_and_sort(input q16_t value, input logic is_last);
        q16_t             ordered[$];
        q16_t             key;
        int               j;
        logic [CNT_W-1:0] placements;
        sorted_result_t   res;
        // items past capacity are discarded but still flag the set
        if (loaded_values.size() < MAX_ELEMENTS)
            loaded_values.push_back(value);
        else
            set_overflow = 1'b1;
        if (is_last) begin
            ordered = loaded_values;
            // stable insertion sort: strict compare keeps equal values in order
            for (int i = 1; i < ordered.size(); i++) begin
                key = ordered[i];
                j   = i;
                while (j > 0 && ordered[j-1] > key) begin
                    ordered[j] = ordered[j-1];
                    j--;
                end
                ordered[j] = key;
            end
            placements = CNT_W'(merge_placements(ordered.size()));
            foreach (ordered[k]) begin
                res.value_res        = ordered[k];
                res.comparison_count = placements;
                res.dropped          = set_overflow;
                res.last_res         = (k == ordered.size() - 1);
                sorted_queue.push_back(res);
            end
            if (set_overflow)
                dropped_sets++;
            sets_closed++;
            loaded_values.delete();
            set_overflow = 1'b0;
        end
    endtask

    // compare one result transfer with the oldest expected result
    task automatic check_result();
        sorted_result_t want;
        results_checked++;
        if (sorted_queue.size() == 0) begin
            $error("result transfer with nothing expected: value_res %0d", m_value_res);
            error_count++;
        end else begin
            want = sorted_queue.pop_front();
            if (m_value_res !== want.value_res) begin
                $error("value_res mismatch: expected %0d, actual %0d",
                       want.value_res, m_value_res);
                error_count++;
            end
            if (m_comparison_count !== want.comparison_count) begin
                $error("comparison_count mismatch: expected %0d, actual %0d",
                       want.comparison_count, m_comparison_count);
                error_count++;
            end
            if (m_dropped !== want.dropped) begin
                $error("dropped mismatch: expected %0d, actual %0d",
                       want.dropped, m_dropped);
                error_count++;
            end
            if (m_last_res !== want.last_res) begin
                $error("last_res mismatch: expected %0d, actual %0d",
                       want.last_res, m_last_res);
                error_count++;
            end
        end
    endtask

    // result sink: check each transfer, then choose ready for the next cycle;
    // a requested hold keeps ready low for a long counted stretch
    always @(posedge aclk) begin
        if (m_valid && m_ready)
            check_result();
        if (hold_requests != holds_served) begin
            holds_served++;
            hold_left = RX_HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // watchdog: ends the run once no transfer has happened for too long
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("merge_sort_with_count test failed");
        $finish;
    end

    // random element: full range, a narrow band for ties, or near the extremes
    function automatic q16_t rand_value();
        case ($urandom_range(3))
            0: return $signed($urandom_range(8)) - 4;
            1: return $urandom_range(1) ? 32'sh7fffffff - $urandom_range(3)
                                        : 32'sh80000000 + $urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    // offer one item and hold it until the transfer; valid drops only when
    // an idle gap follows, so it is never lowered and raised in one step
    task automatic send_item(input q16_t value, input logic is_last);
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_valid <= 1'b1;
        s_value <= value;
        s_last  <= is_last;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        load_and_sort(value, is_last);
    endtask

    // one set of random values, marked last on its final item
    task automatic send_set(input int size);
        for (int i = 0; i < size; i++)
            send_item(rand_value(), i == size - 1);
    endtask

    // sender goes quiet until every expected result has come back
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sorted_queue.size() != 0);
    endtask

    // two one-element sets: no merge, zero count, each marked last
    task automatic test_single_element();
        send_item(32'sh80000000, 1'b1);
        send_item(32'sh7fffffff, 1'b1);
    endtask

    task automatic test_two_elements();
        send_item(32'sd5, 1'b0);
        send_item(-32'sd5, 1'b1);
        send_item(-32'sd5, 1'b0);
        send_item(32'sd5, 1'b1);
    endtask

    // both extremes, zero, one lsb either side, repeated values
    task automatic test_extremes_and_ties();
        send_item(32'sh7fffffff, 1'b0);
        send_item(32'sh80000000, 1'b0);
        send_item(32'sd0, 1'b0);
        send_item(-32'sd1, 1'b0);
        send_item(32'sh7fffffff, 1'b0);
        send_item(32'sh00010000, 1'b0);
        send_item(32'sh80000000, 1'b0);
        send_item(32'sd1, 1'b1);
    endtask

    // odd length: the left half gets the extra element at every split of an odd segment
    task automatic test_uneven_split();
        send_item(32'sh00040000, 1'b0);
        send_item(32'sh00030000, 1'b0);
        send_item(32'sh00020000, 1'b0);
        send_item(-32'sh00018000, 1'b0);
        send_item(32'sh00000000, 1'b1);
    endtask

    // exactly fills the store: largest count, nothing dropped
    task automatic test_full_store();
        send_set(MAX_ELEMENTS);
    endtask

    // two non-final items and the closing item all arrive with the store full
    task automatic test_store_overflow();
        send_set(MAX_ELEMENTS + 3);
    endtask

    // hold the output long enough that the block fills up and stalls its
    // input, then let everything drain before going on
    task automatic test_output_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_requests++;
        send_set(16);
        send_set(16);
        wait_for_drain();
    endtask

    // random sets, mostly short, under one idling pattern
    task automatic test_random_sets(input int tx_pct, input int rx_pct, input int items);
        int start;
        start        = items_sent;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        while (items_sent - start < items)
            send_set(($urandom_range(99) < 70) ? $urandom_range(1, 6)
                                                : $urandom_range(7, 16));
    endtask

    initial begin : test_sequence
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_value <= '0;
        s_last  <= 1'b0;
        m_ready <= 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_single_element();
        test_two_elements();
        test_extremes_and_ties();
        test_uneven_split();
        test_full_store();
        test_store_overflow();
        test_output_backpressure();
        test_random_sets(0, 0, 10);
        test_random_sets(76, 0, 10);
        test_random_sets(0, 76, 10);
        test_random_sets(30, 30, 10);

        wait_for_drain();
        rx_stall_pct = 0;
        repeat (END_SETTLE_CYCLES) @(posedge aclk);

        $display("run covered %0d input items in %0d sets, %0d with dropped items,",
                 items_sent, sets_closed, dropped_sets);
        $display("and %0d sorted results checked under four idling patterns",
                 results_checked);
        if (error_count == 0)
            $display("merge_sort_with_count test passed");
        else
            $display("merge_sort_with_count test failed");
        $finish;
    end

endmodule
